>>> src/arm_media_insn_decoder_top_assert.svh
// Assertion macros for the media instruction decoder.
`ifndef ARM_MEDIA_INSN_DECODER_TOP_ASSERT_SVH
`define ARM_MEDIA_INSN_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define AMID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AMID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AMID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define AMID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/amid_pkg.sv
// Shared types and constants of the media instruction decoder.
package amid_pkg;

    localparam int INSN_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] ST_UNDEF   = 2'd0;
    localparam logic [1:0] ST_DECODED = 2'd1;
    localparam logic [1:0] ST_UNIMPL  = 2'd2;

    localparam logic [3:0] K_BFC     = 4'd0;
    localparam logic [3:0] K_BFI     = 4'd1;
    localparam logic [3:0] K_SBFX    = 4'd2;
    localparam logic [3:0] K_UBFX    = 4'd3;
    localparam logic [3:0] K_DUALMUL = 4'd4;
    localparam logic [3:0] K_MSMUL   = 4'd5;
    localparam logic [3:0] K_SSAT    = 4'd6;
    localparam logic [3:0] K_REV     = 4'd7;
    localparam logic [3:0] K_REV16   = 4'd8;
    localparam logic [3:0] K_REVSH   = 4'd9;
    localparam logic [3:0] K_SXTB    = 4'd10;
    localparam logic [3:0] K_SXTH    = 4'd11;
    localparam logic [3:0] K_UXTB    = 4'd12;
    localparam logic [3:0] K_UXTH    = 4'd13;

    localparam logic [CFG_IDX_W-1:0] CFG_V6_MEDIA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITFIELD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_REV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_ROT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_DIVIDE  = 3'd4;

    localparam logic [3:0]  REG_PC     = 4'hF;
    localparam logic [31:0] ALL_ONES   = 32'hFFFFFFFF;
    localparam logic [6:0]  TOP_BFI    = 7'h3E;
    localparam logic [6:0]  TOP_SBFX   = 7'h3D;
    localparam logic [6:0]  TOP_UBFX   = 7'h3F;
    localparam logic [4:0]  O1_ALL     = 5'h1F;
    localparam logic [4:0]  O1_PAIR    = 5'h1E;
    localparam logic [4:0]  O1_BF_A    = 5'h1A;
    localparam logic [4:0]  O1_BF_B    = 5'h1C;
    localparam logic [4:0]  O1_BF_C    = 5'h1E;
    localparam logic [4:0]  O1_USAD    = 5'h18;

    typedef struct packed {
        logic v6_media;
        logic bitfield_ops;
        logic byte_reverse;
        logic extend_rotate;
        logic integer_divide;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  kind;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [5:0]  aux;
        logic [4:0]  mode;
        logic        fn;
        logic        fu;
        logic [31:0] imm;
    } result_t;

endpackage

>>> src/amid_cfg.sv
// Feature-enable register file of the media instruction decoder.
module amid_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [amid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    output amid_pkg::cfg_t                 cfg
);
    import amid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_V6_MEDIA:   cfg_next.v6_media       = cfg_data;
                CFG_BITFIELD:   cfg_next.bitfield_ops   = cfg_data;
                CFG_BYTE_REV:   cfg_next.byte_reverse   = cfg_data;
                CFG_EXTEND_ROT: cfg_next.extend_rotate  = cfg_data;
                CFG_INT_DIVIDE: cfg_next.integer_divide = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.v6_media       <= 1'b1;
            cfg_reg.bitfield_ops   <= 1'b1;
            cfg_reg.byte_reverse   <= 1'b1;
            cfg_reg.extend_rotate  <= 1'b1;
            cfg_reg.integer_divide <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/amid_decode.sv
// Combinational classifier of one media instruction word.
module amid_decode (
    input  amid_pkg::cfg_t                 cfg,
    input  logic [amid_pkg::INSN_W-1:0]    insn,
    output amid_pkg::result_t              res
);
    import amid_pkg::*;

    function automatic result_t f_bitfield(input logic [31:0] w, input logic en);
        result_t    r;
        logic [6:0] top;
        logic [2:0] b64;
        logic [3:0] rd;
        logic [3:0] rn;
        logic [4:0] lsb;
        logic [4:0] hi;
        logic [5:0] width;
        logic [6:0] span;
        r     = '0;
        top   = w[27:21];
        b64   = w[6:4];
        rd    = w[15:12];
        rn    = w[3:0];
        lsb   = w[11:7];
        hi    = w[20:16];
        width = '0;
        span  = '0;
        if (en)
        begin
            if (top == TOP_BFI && b64 == 3'd1)
            begin
                if (hi >= lsb && rd != REG_PC)
                begin
                    width    = {1'b0, hi} - {1'b0, lsb} + 6'd1;
                    r.status = ST_DECODED;
                    r.kind   = (rn == REG_PC) ? K_BFC : K_BFI;
                    r.rd     = rd;
                    r.rn     = rn;
                    r.aux    = width;
                    r.mode   = lsb;
                    r.imm    = (ALL_ONES << lsb) & (ALL_ONES >> (5'd31 - hi));
                end
            end
            else if ((top == TOP_SBFX || top == TOP_UBFX) && b64 == 3'd5)
            begin
                width = {1'b0, hi} + 6'd1;
                span  = {2'b00, lsb} + {1'b0, width};
                if (span <= 7'd32 && rd != REG_PC && rn != REG_PC)
                begin
                    r.status = ST_DECODED;
                    r.kind   = (top == TOP_SBFX) ? K_SBFX : K_UBFX;
                    r.rd     = rd;
                    r.rn     = rn;
                    r.aux    = width;
                    r.mode   = lsb;
                end
            end
        end
        return r;
    endfunction

    function automatic result_t f_multiply(input logic [31:0] w, input logic dual,
                                           input logic is_long);
        result_t    r;
        logic [3:0] rd;
        logic [3:0] ra;
        logic [3:0] rm;
        logic [3:0] rn;
        logic       ok;
        r  = '0;
        rd = w[19:16];
        ra = w[15:12];
        rm = w[11:8];
        rn = w[3:0];
        ok = (rd != REG_PC) && (rm != REG_PC) && (rn != REG_PC);
        if (dual)
        begin
            if (is_long && (ra == REG_PC || ra == rd))
                ok = 1'b0;
            r.kind = K_DUALMUL;
            r.mode = is_long ? 5'd2 : ((ra == REG_PC) ? 5'd0 : 5'd1);
        end
        else
        begin
            if (w[6] && ra == REG_PC)
                ok = 1'b0;
            r.kind = K_MSMUL;
            r.mode = (ra == REG_PC) ? 5'd0 : 5'd1;
        end
        r.status = ST_DECODED;
        r.fn     = w[6];
        r.fu     = w[5];
        r.rd     = rd;
        r.aux    = {2'b00, ra};
        r.rm     = rm;
        r.rn     = rn;
        if (!ok)
            r = '0;
        return r;
    endfunction

    function automatic result_t f_mul_group(input logic [31:0] w, input logic div_en);
        result_t    r;
        logic [2:0] s;
        logic [2:0] o2;
        r  = '0;
        s  = w[22:20];
        o2 = w[7:5];
        if (s == 3'd0 || s == 3'd4)
        begin
            if (!o2[2])
                r = f_multiply(w, 1'b1, s == 3'd4);
        end
        else if (s == 3'd5)
        begin
            if (o2[2:1] == 2'b00 || o2[2:1] == 2'b11)
                r = f_multiply(w, 1'b0, 1'b0);
        end
        else if (s == 3'd1 || s == 3'd3)
        begin
            if (o2 == 3'd0 && div_en)
                r.status = ST_UNIMPL;
        end
        return r;
    endfunction

    function automatic result_t f_ssat(input logic [31:0] w);
        result_t    r;
        logic [3:0] rd;
        logic [3:0] rn;
        logic [4:0] imm5;
        logic       sh;
        r    = '0;
        rd   = w[15:12];
        rn   = w[3:0];
        imm5 = w[11:7];
        sh   = w[6];
        if (rd != REG_PC && rn != REG_PC)
        begin
            r.status = ST_DECODED;
            r.kind   = K_SSAT;
            r.rd     = rd;
            r.rn     = rn;
            r.mode   = sh ? 5'd2 : 5'd0;
            r.aux    = (sh && imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
            r.imm    = {27'd0, w[20:16]} + 32'd1;
        end
        return r;
    endfunction

    function automatic result_t f_pack_sat_rev(input logic [31:0] w, input cfg_t c);
        result_t    r;
        logic [2:0] f1;
        logic [2:0] f2;
        logic [3:0] rd;
        logic [3:0] rm;
        logic [3:0] b118;
        logic [3:0] a;
        r    = '0;
        f1   = w[22:20];
        f2   = w[7:5];
        rd   = w[15:12];
        rm   = w[3:0];
        b118 = w[11:8];
        a    = w[19:16];
        if (!f2[0])
        begin
            if (f1[2:1] == 2'b01)
                r = f_ssat(w);
            else if (f1 == 3'd0 || f1[2:1] == 2'b11)
                r.status = ST_UNIMPL;
        end
        else if (f2 == 3'd1 || f2 == 3'd5)
        begin
            if (f1 == 3'd3 || (f1 == 3'd7 && f2 == 3'd5))
            begin
                if (c.byte_reverse && a == REG_PC && b118 == REG_PC
                    && rd != REG_PC && rm != REG_PC)
                begin
                    r.status = ST_DECODED;
                    r.kind   = (f2 == 3'd1) ? K_REV : ((f1 == 3'd3) ? K_REV16 : K_REVSH);
                    r.rd     = rd;
                    r.rm     = rm;
                end
            end
            else if (f2 == 3'd1 && f1[1:0] == 2'b10)
            begin
                r.status = ST_UNIMPL;
            end
            else if (f2 == 3'd1 && f1 == 3'd7)
            begin
                if (c.bitfield_ops)
                    r.status = ST_UNIMPL;
            end
            else if (f2 == 3'd5 && f1 == 3'd0)
            begin
                r.status = ST_UNIMPL;
            end
        end
        else if (f2 == 3'd3)
        begin
            if (f1 == 3'd0 || f1 == 3'd4)
            begin
                r.status = ST_UNIMPL;
            end
            else if (f1[1])
            begin
                if (a != REG_PC)
                begin
                    r.status = ST_UNIMPL;
                end
                else if (c.extend_rotate && b118[1:0] == 2'b00
                         && rd != REG_PC && rm != REG_PC)
                begin
                    r.status = ST_DECODED;
                    unique case (f1)
                        3'd2:    r.kind = K_SXTB;
                        3'd3:    r.kind = K_SXTH;
                        3'd6:    r.kind = K_UXTB;
                        default: r.kind = K_UXTH;
                    endcase
                    r.rd   = rd;
                    r.rm   = rm;
                    r.mode = {3'b000, b118[3:2]};
                end
            end
        end
        return r;
    endfunction

    logic [4:0] o1;
    logic [2:0] o2;
    logic       is_bf;
    result_t    raw;

    assign o1 = insn[24:20];
    assign o2 = insn[7:5];
    assign is_bf = ((o1 & O1_PAIR) == O1_BF_A && o2[1:0] == 2'b10)
                || ((o1 & O1_PAIR) == O1_BF_B && o2[1:0] == 2'b00)
                || ((o1 & O1_PAIR) == O1_BF_C && o2[1:0] == 2'b10);

    always_comb
    begin
        raw = '0;
        if (cfg.v6_media && !(o1 == O1_ALL && o2 == 3'd7))
        begin
            if (is_bf)
            begin
                raw = f_bitfield(insn, cfg.bitfield_ops);
            end
            else if (o1[4:3] == 2'b01)
            begin
                raw = f_pack_sat_rev(insn, cfg);
            end
            else if (o1[4:3] == 2'b00)
            begin
                if (!(o1[1:0] == 2'b00 || o2 == 3'd5 || o2 == 3'd6))
                    raw.status = ST_UNIMPL;
            end
            else if (o1[4:3] == 2'b10)
            begin
                raw = f_mul_group(insn, cfg.integer_divide);
            end
            else if (o1 == O1_USAD && o2 == 3'd0)
            begin
                raw.status = ST_UNIMPL;
            end
        end
    end

    always_comb
    begin
        res = raw;
        if (raw.status != ST_DECODED)
        begin
            res        = '0;
            res.status = raw.status;
        end
    end

endmodule

>>> src/arm_media_insn_decoder_top.sv
// Top level of the media instruction decoder: input stage, decode, result stage.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, insn_word         | item in
//  out     | out_valid, out_stall, status..immediate| item out
//  cfg     | cfg_write, cfg_index, cfg_data        | register write
//
// One item per cycle sustained unless the output stalls; an accepted item passes
// through the input register and then the result register around the decode logic.
// Reset clears both stage valid bits and loads the feature enables to their defaults.
// A stalled result holds; one more item is taken into the input register behind it.
module arm_media_insn_decoder_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [amid_pkg::INSN_W-1:0]    insn_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [3:0]                     op_kind,
    output logic [3:0]                     dest_reg,
    output logic [3:0]                     first_src_reg,
    output logic [3:0]                     second_src_reg,
    output logic [5:0]                     aux_value,
    output logic [4:0]                     sub_mode,
    output logic                           flag_n,
    output logic                           flag_u,
    output logic [31:0]                    immediate,
    input  logic                           cfg_write,
    input  logic [amid_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import amid_pkg::*;

    `include "arm_media_insn_decoder_top_assert.svh"

    cfg_t              cfg;
    result_t           decoded;
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [INSN_W-1:0] insn_reg;
    logic [INSN_W-1:0] insn_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           result_reg;
    result_t           result_next;
    logic              drain;
    logic              accept;

    amid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    amid_decode u_decode (
        .cfg  (cfg),
        .insn (insn_reg),
        .res  (decoded)
    );

    assign drain    = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !drain;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next  = in_stall ? in_valid_reg : in_valid;
        insn_next      = accept ? insn_word : insn_reg;
        out_valid_next = drain ? in_valid_reg : out_valid_reg;
        result_next    = (drain && in_valid_reg) ? decoded : result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        insn_reg   <= insn_next;
        result_reg <= result_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign op_kind        = result_reg.kind;
    assign dest_reg       = result_reg.rd;
    assign first_src_reg  = result_reg.rn;
    assign second_src_reg = result_reg.rm;
    assign aux_value      = result_reg.aux;
    assign sub_mode       = result_reg.mode;
    assign flag_n         = result_reg.fn;
    assign flag_u         = result_reg.fu;
    assign immediate      = result_reg.imm;

    `AMID_ASSERT_IMP(a_stall_only_when_blocked, clk, rst_n, in_stall,
        out_valid_reg && out_stall, "input stalled while result stage can drain")
    `AMID_ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, accept,
        in_valid_reg, "accepted item missing from input stage")
    `AMID_ASSERT_IMP(a_fields_zero_unless_decoded, clk, rst_n,
        out_valid_reg && result_reg.status != ST_DECODED,
        result_reg.kind == 4'd0 && result_reg.rd == 4'd0 && result_reg.rn == 4'd0
        && result_reg.rm == 4'd0 && result_reg.aux == 6'd0 && result_reg.imm == 32'd0,
        "non-decoded item carries field data")
    `AMID_ASSERT_IMP(a_bitfield_mask_nonzero, clk, rst_n,
        out_valid_reg && result_reg.status == ST_DECODED
        && (result_reg.kind == K_BFI || result_reg.kind == K_BFC),
        result_reg.imm != 32'd0, "bitfield item with empty mask")

endmodule

>>> tb/arm_media_insn_decoder_checker.sv
// Decode predictor and result scoreboard for the media instruction decoder.
module arm_media_insn_decoder_checker import amid_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [INSN_W-1:0]    insn_word,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           status,
    input  logic [3:0]           op_kind,
    input  logic [3:0]           dest_reg,
    input  logic [3:0]           first_src_reg,
    input  logic [3:0]           second_src_reg,
    input  logic [5:0]           aux_value,
    input  logic [4:0]           sub_mode,
    input  logic                 flag_n,
    input  logic                 flag_u,
    input  logic [31:0]          immediate,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    output int                   mismatch_count,
    output int                   pending_items
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam cfg_t       FEATURES_AT_RESET = 5'b11110;
    localparam logic [4:0] MAC_NONE  = 5'd0;
    localparam logic [4:0] MAC_ACC   = 5'd1;
    localparam logic [4:0] MAC_LONG  = 5'd2;
    localparam logic [4:0] SHIFT_LSL = 5'd0;
    localparam logic [4:0] SHIFT_ASR = 5'd2;

    cfg_t    features;
    result_t expected_results[$];
    int      errors = 0;
    int      pending = 0;

    assign mismatch_count = errors;
    assign pending_items  = pending;

    function automatic result_t predict_multiply(logic [31:0] w, logic dual, logic long_form);
        result_t    r;
        logic [3:0] rd;
        logic [3:0] ra;
        logic [3:0] rm;
        logic [3:0] rn;
        r  = '0;
        rd = w[19:16];
        ra = w[15:12];
        rm = w[11:8];
        rn = w[3:0];
        if (rd != REG_PC && rm != REG_PC && rn != REG_PC)
        begin
            if (dual ? !(long_form && (ra == REG_PC || ra == rd)) : !(w[6] && ra == REG_PC))
            begin
                r.status = ST_DECODED;
                r.kind   = dual ? K_DUALMUL : K_MSMUL;
                r.mode   = (dual && long_form) ? MAC_LONG : (ra == REG_PC) ? MAC_NONE : MAC_ACC;
                r.fn     = w[6];
                r.fu     = w[5];
                r.rd     = rd;
                r.aux    = {2'b00, ra};
                r.rm     = rm;
                r.rn     = rn;
            end
        end
        return r;
    endfunction

    function automatic result_t predict_decode(logic [31:0] w, cfg_t f);
        result_t    r;
        logic [4:0] o1;
        logic [2:0] o2;
        logic [2:0] f1;
        logic [6:0] top;
        logic [3:0] rd;
        logic [3:0] r0;
        logic [3:0] hi_reg;
        logic [3:0] mid;
        logic [4:0] lsb;
        logic [4:0] msb;
        logic [5:0] width;
        logic [1:0] st;
        r      = '0;
        o1     = w[24:20];
        o2     = w[7:5];
        f1     = w[22:20];
        top    = w[27:21];
        rd     = w[15:12];
        r0     = w[3:0];
        hi_reg = w[19:16];
        mid    = w[11:8];
        lsb    = w[11:7];
        msb    = w[20:16];
        if (!f.v6_media || (o1 == O1_ALL && o2 == 3'd7))
        begin
            r.status = ST_UNDEF;
        end
        else if (((o1 & O1_PAIR) == O1_BF_A && o2[1:0] == 2'd2) ||
                 ((o1 & O1_PAIR) == O1_BF_B && o2[1:0] == 2'd0) ||
                 ((o1 & O1_PAIR) == O1_BF_C && o2[1:0] == 2'd2))
        begin
            if (f.bitfield_ops && top == TOP_BFI && w[6:4] == 3'd1)
            begin
                if (msb >= lsb && rd != REG_PC)
                begin
                    width    = {1'b0, msb} - {1'b0, lsb} + 6'd1;
                    r.status = ST_DECODED;
                    r.kind   = (r0 == REG_PC) ? K_BFC : K_BFI;
                    r.rd     = rd;
                    r.rn     = r0;
                    r.aux    = width;
                    r.mode   = lsb;
                    r.imm    = (width == 6'd32) ? ALL_ONES
                                                : (((32'd1 << width) - 32'd1) << lsb);
                end
            end
            else if (f.bitfield_ops && (top == TOP_SBFX || top == TOP_UBFX) && w[6:4] == 3'd5)
            begin
                width = {1'b0, msb} + 6'd1;
                if ({2'b00, lsb} + {1'b0, width} <= 7'd32 && rd != REG_PC && r0 != REG_PC)
                begin
                    r.status = ST_DECODED;
                    r.kind   = (top == TOP_SBFX) ? K_SBFX : K_UBFX;
                    r.rd     = rd;
                    r.rn     = r0;
                    r.aux    = width;
                    r.mode   = lsb;
                end
            end
        end
        else if (o1[4:3] == 2'b01)
        begin
            if (!o2[0])
            begin
                if (f1[2:1] == 2'b01)
                begin
                    if (rd != REG_PC && r0 != REG_PC)
                    begin
                        r.status = ST_DECODED;
                        r.kind   = K_SSAT;
                        r.rd     = rd;
                        r.rn     = r0;
                        r.mode   = w[6] ? SHIFT_ASR : SHIFT_LSL;
                        r.aux    = (w[6] && lsb == 5'd0) ? 6'd32 : {1'b0, lsb};
                        r.imm    = 32'(msb) + 32'd1;
                    end
                end
                else if (f1 == 3'd0 || f1[2:1] == 2'b11)
                    r.status = ST_UNIMPL;
            end
            else if (o2 == 3'd1 || o2 == 3'd5)
            begin
                if (f1 == 3'd3 || (f1 == 3'd7 && o2 == 3'd5))
                begin
                    if (f.byte_reverse && hi_reg == REG_PC && mid == REG_PC &&
                        rd != REG_PC && r0 != REG_PC)
                    begin
                        r.status = ST_DECODED;
                        r.kind   = (o2 == 3'd1) ? K_REV : (f1 == 3'd3) ? K_REV16 : K_REVSH;
                        r.rd     = rd;
                        r.rm     = r0;
                    end
                end
                else if (o2 == 3'd1 && f1[1:0] == 2'd2)
                    r.status = ST_UNIMPL;
                else if (o2 == 3'd1 && f1 == 3'd7)
                begin
                    if (f.bitfield_ops)
                        r.status = ST_UNIMPL;
                end
                else if (o2 == 3'd5 && f1 == 3'd0)
                    r.status = ST_UNIMPL;
            end
            else if (o2 == 3'd3)
            begin
                if (f1 == 3'd0 || f1 == 3'd4)
                    r.status = ST_UNIMPL;
                else if (f1[1])
                begin
                    if (hi_reg != REG_PC)
                        r.status = ST_UNIMPL;
                    else if (f.extend_rotate && mid[1:0] == 2'd0 && rd != REG_PC && r0 != REG_PC)
                    begin
                        r.status = ST_DECODED;
                        case (f1)
                            3'd2:    r.kind = K_SXTB;
                            3'd3:    r.kind = K_SXTH;
                            3'd6:    r.kind = K_UXTB;
                            default: r.kind = K_UXTH;
                        endcase
                        r.rd   = rd;
                        r.rm   = r0;
                        r.mode = {3'b000, mid[3:2]};
                    end
                end
            end
        end
        else if (o1[4:3] == 2'b00)
        begin
            if (!(o1[1:0] == 2'd0 || o2 == 3'd5 || o2 == 3'd6))
                r.status = ST_UNIMPL;
        end
        else if (o1[4:3] == 2'b10)
        begin
            case (o1[2:0])
                3'd0, 3'd4:
                begin
                    if (!o2[2])
                        r = predict_multiply(w, 1'b1, o1[2]);
                end
                3'd5:
                begin
                    if (o2[2:1] == 2'b00 || o2[2:1] == 2'b11)
                        r = predict_multiply(w, 1'b0, 1'b0);
                end
                3'd1, 3'd3:
                begin
                    if (o2 == 3'd0 && f.integer_divide)
                        r.status = ST_UNIMPL;
                end
                default:
                begin
                end
            endcase
        end
        else if (o1 == O1_USAD && o2 == 3'd0)
        begin
            r.status = ST_UNIMPL;
        end
        if (r.status != ST_DECODED)
        begin
            st       = r.status;
            r        = '0;
            r.status = st;
        end
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            features <= FEATURES_AT_RESET;
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_V6_MEDIA:   features.v6_media       <= cfg_data;
                CFG_BITFIELD:   features.bitfield_ops   <= cfg_data;
                CFG_BYTE_REV:   features.byte_reverse   <= cfg_data;
                CFG_EXTEND_ROT: features.extend_rotate  <= cfg_data;
                CFG_INT_DIVIDE: features.integer_divide <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : score_results
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item arrived with no instruction pending");
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", 32'(want.status), 32'(status));
                    compare_field("op_kind", 32'(want.kind), 32'(op_kind));
                    compare_field("dest_reg", 32'(want.rd), 32'(dest_reg));
                    compare_field("first_src_reg", 32'(want.rn), 32'(first_src_reg));
                    compare_field("second_src_reg", 32'(want.rm), 32'(second_src_reg));
                    compare_field("aux_value", 32'(want.aux), 32'(aux_value));
                    compare_field("sub_mode", 32'(want.mode), 32'(sub_mode));
                    compare_field("flag_n", 32'(want.fn), 32'(flag_n));
                    compare_field("flag_u", 32'(want.fu), 32'(flag_u));
                    compare_field("immediate", want.imm, immediate);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_decode(insn_word, features));
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb_arm_media_insn_decoder_top.sv
// Testbench top: drives directed and random media instruction words and reports the verdict.
module tb_arm_media_insn_decoder_top import amid_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         HOLD_CYCLES     = 64;
    localparam int         QUIET_LIMIT     = 2000;
    localparam int         DRAIN_CYCLES    = 4;
    localparam int         RANDOM_PHASES   = 7;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam logic [4:0] ROW_DUAL        = 5'h10;
    localparam logic [4:0] ROW_DUAL_LONG   = 5'h14;
    localparam logic [4:0] ROW_MSMUL       = 5'h15;
    localparam cfg_t       FEATURES_DEFAULT = 5'b11110;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [INSN_W-1:0]    insn_word = '0;
    logic                 out_valid;
    logic                 out_stall;
    logic                 stall_rand = 1'b0;
    logic                 stall_hold = 1'b0;
    logic [1:0]           status;
    logic [3:0]           op_kind;
    logic [3:0]           dest_reg;
    logic [3:0]           first_src_reg;
    logic [3:0]           second_src_reg;
    logic [5:0]           aux_value;
    logic [4:0]           sub_mode;
    logic                 flag_n;
    logic                 flag_u;
    logic [31:0]          immediate;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data = 1'b0;
    int                   mismatch_count;
    int                   pending_items;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   quiet_cycles = 0;

    assign out_stall = stall_rand | stall_hold;

    arm_media_insn_decoder_top dut (.*);

    arm_media_insn_decoder_checker checker_i (.*);

    always #6 clk = ~clk;

    always @(negedge clk)
        stall_rand <= ($urandom_range(0, 99) < recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("arm_media_insn_decoder_top regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] make_bf(logic [6:0] top, logic [4:0] msb, logic [3:0] rd,
                                            logic [4:0] lsb, logic [2:0] low, logic [3:0] rn);
        return {4'hE, top, msb, rd, lsb, low, rn};
    endfunction

    function automatic logic [31:0] make_mul(logic [4:0] o1, logic [3:0] rd, logic [3:0] ra,
                                             logic [3:0] rm, logic [2:0] o2, logic [3:0] rn);
        return {4'hE, 3'b011, o1, rd, ra, rm, o2, 1'b1, rn};
    endfunction

    function automatic logic [31:0] make_psr(logic [2:0] f1, logic [3:0] a, logic [3:0] rd,
                                             logic [3:0] mid, logic [2:0] f2, logic [3:0] rm);
        return {4'hE, 3'b011, 2'b01, f1, a, rd, mid, f2, 1'b1, rm};
    endfunction

    function automatic logic [3:0] pick_reg();
        return ($urandom_range(0, 7) == 0) ? REG_PC : 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        logic [6:0]  top;
        logic [4:0]  lsb;
        logic [4:0]  msb;
        int          sel;
        w   = $urandom;
        sel = $urandom_range(0, 9);
        case (sel)
            0:
            begin
            end
            1:
                w[27:25] = 3'b011;
            2, 3:
            begin
                case ($urandom_range(0, 3))
                    0:       top = TOP_BFI;
                    1:       top = TOP_SBFX;
                    2:       top = TOP_UBFX;
                    default: top = {3'b011, w[24:21]};
                endcase
                lsb = 5'($urandom_range(0, 31));
                if (top == TOP_BFI)
                    msb = 5'($urandom_range(lsb, 31));
                else
                    msb = 5'($urandom_range(0, 31 - lsb));
                if ($urandom_range(0, 4) == 0)
                    msb = w[20:16];
                w[27:21] = top;
                w[20:16] = msb;
                w[11:7]  = lsb;
                if ($urandom_range(0, 5) != 0)
                    w[6:4] = (top == TOP_BFI) ? 3'd1 : 3'd5;
                w[15:12] = pick_reg();
                w[3:0]   = pick_reg();
            end
            4, 5:
            begin
                w[27:23] = 5'b01110;
                w[19:16] = pick_reg();
                w[15:12] = pick_reg();
                w[11:8]  = pick_reg();
                w[3:0]   = pick_reg();
                w[7]     = ($urandom_range(0, 3) == 0);
                w[4]     = 1'b1;
            end
            6, 7, 8:
            begin
                w[27:23] = 5'b01101;
                if ($urandom_range(0, 3) != 0)
                    w[19:16] = REG_PC;
                if ($urandom_range(0, 2) == 0)
                    w[11:8] = REG_PC;
                else if ($urandom_range(0, 1) == 0)
                    w[9:8] = 2'b00;
                if (sel == 8)
                    w[7:5] = 3'b011;
                w[15:12] = pick_reg();
                w[3:0]   = pick_reg();
                w[4]     = 1'b1;
            end
            default:
            begin
                w[27:25] = 3'b011;
                w[24:20] = ($urandom_range(0, 1) == 0) ? O1_USAD : O1_ALL;
                if ($urandom_range(0, 1) == 0)
                    w[7:5] = (w[24:20] == O1_USAD) ? 3'd0 : 3'd7;
            end
        endcase
        return w;
    endfunction

    task automatic send_insn(input logic [31:0] w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            insn_word <= $urandom;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        insn_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_items != 0)
            @(negedge clk);
    endtask

    task automatic write_features(input cfg_t f);
        logic                 bit_val;
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < (1 << CFG_IDX_W); i++)
        begin
            idx = CFG_IDX_W'(i);
            case (idx)
                CFG_V6_MEDIA:   bit_val = f.v6_media;
                CFG_BITFIELD:   bit_val = f.bitfield_ops;
                CFG_BYTE_REV:   bit_val = f.byte_reverse;
                CFG_EXTEND_ROT: bit_val = f.extend_rotate;
                CFG_INT_DIVIDE: bit_val = f.integer_divide;
                default:        bit_val = 1'($urandom_range(0, 1));
            endcase
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= bit_val;
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [31:0] directed_items[$];
        cfg_t        feats;
        directed_items = '{
            32'h0000_0000,
            32'hFFFF_FFFF,
            make_bf(TOP_BFI, 5'd11, 4'd2, 5'd4, 3'd1, 4'd3),
            make_bf(TOP_BFI, 5'd31, 4'd1, 5'd0, 3'd1, REG_PC),
            make_bf(TOP_BFI, 5'd3, 4'd6, 5'd9, 3'd1, 4'd7),
            make_bf(TOP_SBFX, 5'd7, 4'd8, 5'd8, 3'd5, 4'd9),
            make_bf(TOP_UBFX, 5'd31, 4'd10, 5'd0, 3'd5, 4'd11),
            make_bf(TOP_UBFX, 5'd15, 4'd0, 5'd20, 3'd5, 4'd1),
            make_mul(ROW_DUAL, 4'd1, 4'd2, 4'd3, 3'b000, 4'd4),
            make_mul(ROW_DUAL, 4'd5, REG_PC, 4'd6, 3'b011, 4'd7),
            make_mul(ROW_DUAL_LONG, 4'd8, 4'd9, 4'd10, 3'b010, 4'd11),
            make_mul(ROW_DUAL_LONG, 4'd8, 4'd8, 4'd10, 3'b000, 4'd11),
            make_mul(ROW_MSMUL, 4'd12, 4'd13, 4'd14, 3'b000, 4'd0),
            make_mul(ROW_MSMUL, 4'd12, REG_PC, 4'd14, 3'b001, 4'd0),
            make_mul(ROW_MSMUL, 4'd12, REG_PC, 4'd14, 3'b110, 4'd0),
            make_psr(3'd3, 4'hF, 4'd4, 4'h0, 3'b010, 4'd5),
            make_psr(3'd2, 4'h0, 4'd6, 4'hF, 3'b100, 4'd7),
            make_psr(3'd3, REG_PC, 4'd4, REG_PC, 3'd1, 4'd5),
            make_psr(3'd3, REG_PC, 4'd6, REG_PC, 3'd5, 4'd7),
            make_psr(3'd7, REG_PC, 4'd8, REG_PC, 3'd5, 4'd9),
            make_psr(3'd2, REG_PC, 4'd1, 4'h4, 3'd3, 4'd2),
            make_psr(3'd3, REG_PC, 4'd3, 4'h8, 3'd3, 4'd4),
            make_psr(3'd6, REG_PC, 4'd5, 4'hC, 3'd3, 4'd6),
            make_psr(3'd7, REG_PC, 4'd7, 4'h0, 3'd3, 4'd8),
            make_psr(3'd2, 4'h3, 4'd1, 4'h0, 3'd3, 4'd2),
            make_psr(3'd7, REG_PC, 4'd1, REG_PC, 3'd1, 4'd2),
            make_mul(O1_USAD, 4'd1, REG_PC, 4'd2, 3'b000, 4'd3),
            make_mul(O1_ALL, 4'd1, 4'd2, 4'd3, 3'b111, 4'd4)
        };
        send_idle_pct = 20;
        recv_idle_pct = 46;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_items[i])
            send_insn(directed_items[i]);
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            case (phase)
                0:       feats = '1;
                1:       feats = '0;
                2:       feats = cfg_t'(5'b10000);
                6:       feats = FEATURES_DEFAULT;
                default: feats = cfg_t'({1'b1, 4'($urandom_range(0, 15))});
            endcase
            write_features(feats);
            send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 46 : 0;
            recv_idle_pct = (phase < 2) ? 46 : (phase < 4) ? 20 : 0;
            if (phase == 4)
            begin
                fork
                    begin
                        stall_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(negedge clk);
                        stall_hold <= 1'b0;
                    end
                join_none
            end
            repeat (ITEMS_PER_PHASE)
                send_insn(random_insn());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("arm_media_insn_decoder_top regression: pass");
        else
            $display("arm_media_insn_decoder_top regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/amid_pkg.sv
src/amid_cfg.sv
src/amid_decode.sv
src/arm_media_insn_decoder_top.sv
tb/arm_media_insn_decoder_checker.sv
tb/tb_arm_media_insn_decoder_top.sv
